### sv/arpc_pkg.sv
// Package for the ARP cache and responder: item types, codes and constants.
`timescale 1ns / 1ps

package arpc_pkg;

   localparam int CACHE_ENTRIES_DEF = 16;
   localparam int CSR_ADDR_W        = 4;

   localparam logic [15:0] MIN_PACKET_LEN = 16'd28;
   localparam logic [15:0] HW_ETHERNET    = 16'h0001;
   localparam logic [15:0] PROTO_IPV4     = 16'h0800;
   localparam logic [15:0] OP_REQUEST     = 16'h0001;
   localparam logic [15:0] OP_REPLY       = 16'h0002;
   localparam logic [47:0] BCAST_MAC      = 48'hFFFF_FFFF_FFFF;

   localparam logic KIND_PACKET  = 1'b0;
   localparam logic KIND_RESOLVE = 1'b1;

   localparam logic [2:0] ACT_DROP  = 3'd0;
   localparam logic [2:0] ACT_LEARN = 3'd1;
   localparam logic [2:0] ACT_REPLY = 3'd2;
   localparam logic [2:0] ACT_HIT   = 3'd3;
   localparam logic [2:0] ACT_MISS  = 3'd4;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] packet_length;
      logic [15:0] hw_type;
      logic [15:0] proto_type;
      logic [15:0] opcode;
      logic [31:0] sender_ip;
      logic [47:0] sender_mac;
      logic [31:0] dest_ip;
   } req_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [47:0] out_mac;
      logic [31:0] out_ip;
   } rsp_type;

endpackage

### sv/arp_cache_and_responder.sv
// ARP cache and responder: IP-to-MAC cache in a memory with sequential lookup.
// A dropped packet gives its result in the cycle after start. A lookup or learn reads
// the cache entry by entry through the read and compare registers until a hit or the last entry.
// The scan reads one entry per cycle from the cache memory read port; a new item is taken
// only while the block is idle (busy low). Results cannot be stalled.
// Reset clears the valid bits and both registers at once; no clearing pass.
`timescale 1ns / 1ps

module arp_cache_and_responder #(
   parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  arpc_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   output arpc_pkg::rsp_type                 rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [arpc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [63:0]                       pwdata,
   output logic [63:0]                       prdata,
   output logic                              pready
);
   import arpc_pkg::*;

   localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

   logic [31:0]              ip_mem  [CACHE_ENTRIES];
   logic [47:0]              mac_mem [CACHE_ENTRIES];

   state_type                state_ff, state_in;
   req_type                  req_ff;
   logic [IDX_W-1:0]         addr_ff, addr_in;
   logic                     issue_ff, issue_in;
   logic                     cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]         cmp_idx_ff, cmp_idx_in;
   logic [31:0]              ip_rd_ff;
   logic [47:0]              mac_rd_ff;
   logic                     free_found_ff, free_found_in;
   logic [IDX_W-1:0]         free_idx_ff, free_idx_in;
   logic [CACHE_ENTRIES-1:0] valid_ff, valid_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;
   logic [31:0]              own_ip_ff;
   logic [47:0]              own_mac_ff;

   logic                     accept, pkt_ok, go_scan, rd_en, mem_we;
   logic [31:0]              key;
   logic                     cur_valid, match, at_last, finish;
   logic [IDX_W-1:0]         free_sel, wr_idx;
   logic                     csr_we;

   assign accept    = start && !busy;
   assign pkt_ok    = (req_data.packet_length >= MIN_PACKET_LEN) &&
                      (req_data.hw_type == HW_ETHERNET) &&
                      (req_data.proto_type == PROTO_IPV4);
   assign go_scan   = (req_data.kind == KIND_RESOLVE) || pkt_ok;
   assign key       = (req_ff.kind == KIND_RESOLVE) ? req_ff.dest_ip : req_ff.sender_ip;
   assign cur_valid = valid_ff[cmp_idx_ff];
   assign match     = cmp_vld_ff && cur_valid && (ip_rd_ff == key);
   assign at_last   = cmp_vld_ff && (cmp_idx_ff == LAST_IDX);
   assign finish    = (state_ff == ST_SCAN) && (match || at_last);
   assign rd_en     = (state_ff == ST_SCAN) && issue_ff;
   assign free_sel  = free_found_ff ? free_idx_ff :
                      ((cmp_vld_ff && !cur_valid) ? cmp_idx_ff : '0);

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // configuration port
   assign pready = 1'b1;
   assign csr_we = psel && penable && pwrite && pready;
   assign prdata = paddr[3] ? {16'b0, own_mac_ff} : {32'b0, own_ip_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff  <= '0;
         own_mac_ff <= '0;
      end else if (csr_we) begin
         if (paddr[3]) begin
            own_mac_ff <= pwdata[47:0];
         end else begin
            own_ip_ff <= pwdata[31:0];
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && go_scan) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      addr_in       = addr_ff;
      issue_in      = issue_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      wr_idx        = match ? cmp_idx_ff : free_sel;
      case (state_ff)
         ST_IDLE: begin
            addr_in       = '0;
            issue_in      = 1'b1;
            free_found_in = 1'b0;
            if (accept && !go_scan) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.action  = ACT_DROP;
               rsp_data_in.out_mac = '0;
               rsp_data_in.out_ip  = '0;
            end
         end
         ST_SCAN: begin
            cmp_vld_in = issue_ff && !finish;
            cmp_idx_in = addr_ff;
            if (issue_ff) begin
               if (addr_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end else begin
                  addr_in = addr_ff + 1'b1;
               end
            end
            if (cmp_vld_ff && !cur_valid && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = cmp_idx_ff;
            end
            if (finish) begin
               rsp_valid_in = 1'b1;
               if (req_ff.kind == KIND_RESOLVE) begin
                  rsp_data_in.action  = match ? ACT_HIT : ACT_MISS;
                  rsp_data_in.out_mac = match ? mac_rd_ff : BCAST_MAC;
                  rsp_data_in.out_ip  = req_ff.dest_ip;
               end else begin
                  mem_we           = 1'b1;
                  valid_in[wr_idx] = 1'b1;
                  if ((req_ff.opcode == OP_REQUEST) && (req_ff.dest_ip == own_ip_ff)) begin
                     rsp_data_in.action  = ACT_REPLY;
                     rsp_data_in.out_mac = req_ff.sender_mac;
                     rsp_data_in.out_ip  = req_ff.sender_ip;
                  end else begin
                     rsp_data_in.action  = ACT_LEARN;
                     rsp_data_in.out_mac = '0;
                     rsp_data_in.out_ip  = '0;
                  end
               end
            end
         end
         default: begin
            issue_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_ff      <= 1'b0;
         cmp_vld_ff    <= 1'b0;
         free_found_ff <= 1'b0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_ff      <= issue_in;
         cmp_vld_ff    <= cmp_vld_in;
         free_found_ff <= free_found_in;
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      cmp_idx_ff  <= cmp_idx_in;
      free_idx_ff <= free_idx_in;
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         req_ff <= req_data;
      end
   end

   // cache memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ip_mem[wr_idx]  <= req_ff.sender_ip;
         mac_mem[wr_idx] <= req_ff.sender_mac;
      end
      if (rd_en) begin
         ip_rd_ff  <= ip_mem[addr_ff];
         mac_rd_ff <= mac_mem[addr_ff];
      end
   end

   a_finish_strobe: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff)
      else $error("finished item gave no result strobe");

   a_scan_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && go_scan) |=> !rsp_valid_ff)
      else $error("result strobe right after a scan started");

   a_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_SCAN) && (req_ff.kind == KIND_PACKET))
      else $error("cache write outside a learning scan");

   a_cmp_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> (state_ff == ST_SCAN))
      else $error("compare stage active outside a scan");

   a_learn_sets_valid: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> valid_ff[$past(wr_idx)])
      else $error("learned entry not marked valid");

endmodule

### dv/tb_top.sv
// Testbench for arp_cache_and_responder: directed and random items, checked against a cache model.
`timescale 1ns / 1ps

module tb_top;
   import arpc_pkg::*;

   localparam int NUM_ENTRIES = CACHE_ENTRIES_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int NUM_PHASES  = 5;
   localparam int PHASE_ITEMS = 306;
   localparam int POOL_SIZE   = 24;
   localparam logic [CSR_ADDR_W-1:0] CSR_OWN_IP  = 4'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_OWN_MAC = 4'd8;

   typedef struct packed {
      req_type item;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [63:0]           pwdata;
   logic [63:0]           prdata;
   logic                  pready;

   bit          model_valid [NUM_ENTRIES];
   logic [31:0] model_ip    [NUM_ENTRIES];
   logic [47:0] model_mac   [NUM_ENTRIES];
   logic [31:0] model_own_ip;
   logic [47:0] model_own_mac;

   rsp_type      pending_answers[$];
   stim_row_type directed_rows[$];
   logic [31:0]  ip_pool[POOL_SIZE];
   int           mismatch_count = 0;
   int           cycle_count = 0;
   bit           no_idle;

   arp_cache_and_responder dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   function automatic int cache_lookup(logic [31:0] ip);
      for (int k = 0; k < NUM_ENTRIES; k++) begin
         if (model_valid[k] && model_ip[k] == ip) return k;
      end
      return -1;
   endfunction

   // Expected answer for one item; updates the cache copy for every packet that is not dropped.
   function automatic rsp_type resolve_or_learn(req_type it);
      rsp_type r;
      int      k;
      r = '0;
      r.action = ACT_DROP;
      if (it.kind == KIND_RESOLVE) begin
         k = cache_lookup(it.dest_ip);
         r.out_ip = it.dest_ip;
         if (k >= 0) begin
            r.action  = ACT_HIT;
            r.out_mac = model_mac[k];
         end else begin
            r.action  = ACT_MISS;
            r.out_mac = BCAST_MAC;
         end
      end else if (it.packet_length >= MIN_PACKET_LEN && it.hw_type == HW_ETHERNET &&
                   it.proto_type == PROTO_IPV4) begin
         k = cache_lookup(it.sender_ip);
         if (k < 0) begin
            k = 0;
            while (k < NUM_ENTRIES && model_valid[k]) k++;
            if (k >= NUM_ENTRIES) k = 0;
            model_ip[k]    = it.sender_ip;
            model_valid[k] = 1'b1;
         end
         model_mac[k] = it.sender_mac;
         if (it.opcode == OP_REQUEST && it.dest_ip == model_own_ip) begin
            r.action  = ACT_REPLY;
            r.out_mac = it.sender_mac;
            r.out_ip  = it.sender_ip;
         end else begin
            r.action = ACT_LEARN;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("unexpected result", 64'(rsp_data), 64'h0);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_data.action !== want.action)
               report_mismatch("action", 64'(rsp_data.action), 64'(want.action));
            if (rsp_data.out_mac !== want.out_mac)
               report_mismatch("out_mac", 64'(rsp_data.out_mac), 64'(want.out_mac));
            if (rsp_data.out_ip !== want.out_ip)
               report_mismatch("out_ip", 64'(rsp_data.out_ip), 64'(want.out_ip));
         end
      end
   end

   function automatic req_type pkt(logic kind, logic [15:0] len, logic [15:0] hw,
                                   logic [15:0] pt, logic [15:0] op, logic [31:0] sip,
                                   logic [47:0] smac, logic [31:0] dip);
      req_type it;
      it.kind          = kind;
      it.packet_length = len;
      it.hw_type       = hw;
      it.proto_type    = pt;
      it.opcode        = op;
      it.sender_ip     = sip;
      it.sender_mac    = smac;
      it.dest_ip       = dip;
      return it;
   endfunction

   function automatic logic [47:0] rand48();
      return {16'($urandom), 32'($urandom)};
   endfunction

   function automatic logic [31:0] pick_ip();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   // Mostly well-formed packets and resolves over a small address pool, some noise.
   function automatic req_type random_item();
      req_type it;
      int      sel;
      sel = $urandom_range(0, 99);
      it  = pkt(KIND_PACKET, 16'($urandom_range(28, 120)), HW_ETHERNET, PROTO_IPV4,
                OP_REQUEST, pick_ip(), rand48(), pick_ip());
      if ($urandom_range(0, 7) == 0) it.packet_length = 16'($urandom_range(28, 65535));
      if (sel < 35) begin
         it.kind = KIND_RESOLVE;
         if ($urandom_range(0, 3) == 0) begin
            it.packet_length = 16'($urandom);
            it.hw_type       = 16'($urandom);
            it.proto_type    = 16'($urandom);
            it.opcode        = 16'($urandom);
         end
      end else if (sel < 85) begin
         case ($urandom_range(0, 3))
            0: it.opcode = OP_REPLY;
            1: it.opcode = 16'($urandom);
            default: it.opcode = OP_REQUEST;
         endcase
         if ($urandom_range(0, 1) == 0) it.dest_ip = model_own_ip;
      end else if (sel < 93) begin
         case ($urandom_range(0, 2))
            0: it.packet_length = 16'($urandom_range(0, 27));
            1: it.hw_type = 16'($urandom);
            default: it.proto_type = 16'($urandom);
         endcase
      end else begin
         it = pkt(KIND_PACKET, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  $urandom, rand48(), $urandom);
      end
      return it;
   endfunction

   task automatic send_item(req_type it, bit typed, rsp_type want, int gap);
      rsp_type r;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      r = resolve_or_learn(it);
      pending_answers.push_back(typed ? want : r);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() > 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == CSR_OWN_IP) model_own_ip = value[31:0];
      else model_own_mac = value[47:0];
   endtask

   function automatic int draw_gap();
      if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
      return no_idle ? 0 : $urandom_range(0, 18);
   endfunction

   initial begin
      logic [31:0] own_ip_set [NUM_PHASES];
      logic [47:0] own_mac_set[NUM_PHASES];
      rsp_type     none;

      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      psel     = 1'b0;
      penable  = 1'b0;
      pwrite   = 1'b0;
      paddr    = '0;
      pwdata   = '0;
      no_idle        = 1'b0;
      none           = '0;
      model_own_ip   = '0;
      model_own_mac  = '0;
      foreach (model_valid[k]) begin
         model_valid[k] = 1'b0;
         model_ip[k]    = '0;
         model_mac[k]   = '0;
      end
      foreach (ip_pool[k]) ip_pool[k] = $urandom;

      own_ip_set  = '{32'h0, 32'hFFFF_FFFF, $urandom, ip_pool[0], $urandom};
      own_mac_set = '{48'hFFFF_FFFF_FFFF, 48'h0, rand48(), rand48(), rand48()};

      directed_rows.push_back(stim_row_type'{pkt(KIND_RESOLVE, 0, 0, 0, 0, 0, 0, 32'h0A00_0001),
                              1'b1, rsp_type'{ACT_MISS, BCAST_MAC, 32'h0A00_0001}});
      directed_rows.push_back(stim_row_type'{pkt(KIND_RESOLVE, 0, 0, 0, 0, 0, 0, 32'h0),
                              1'b1, rsp_type'{ACT_MISS, BCAST_MAC, 32'h0}});
      directed_rows.push_back(stim_row_type'{pkt(KIND_RESOLVE, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF),
                              1'b1, rsp_type'{ACT_MISS, BCAST_MAC, 32'hFFFF_FFFF}});
      // short packets and wrong types are dropped
      directed_rows.push_back(stim_row_type'{pkt(KIND_PACKET, 16'd27, HW_ETHERNET, PROTO_IPV4,
                              OP_REQUEST, 32'h0A00_0009, 48'h1, 32'hC0A8_0001), 1'b1,
                              rsp_type'{ACT_DROP, 48'h0, 32'h0}});
      directed_rows.push_back(stim_row_type'{pkt(KIND_PACKET, 16'd0, HW_ETHERNET, PROTO_IPV4,
                              OP_REQUEST, 32'h0A00_0009, 48'h1, 32'hC0A8_0001), 1'b1,
                              rsp_type'{ACT_DROP, 48'h0, 32'h0}});
      directed_rows.push_back(stim_row_type'{pkt(KIND_PACKET, 16'd28, 16'h0, PROTO_IPV4,
                              OP_REQUEST, 32'h0A00_0009, 48'h1, 32'hC0A8_0001), 1'b1,
                              rsp_type'{ACT_DROP, 48'h0, 32'h0}});
      directed_rows.push_back(stim_row_type'{pkt(KIND_PACKET, 16'hFFFF, 16'hFFFF, PROTO_IPV4,
                              OP_REQUEST, 32'h0A00_0009, 48'h1, 32'hC0A8_0001), 1'b1,
                              rsp_type'{ACT_DROP, 48'h0, 32'h0}});
      directed_rows.push_back(stim_row_type'{pkt(KIND_PACKET, 16'd60, HW_ETHERNET, 16'h86DD,
                              OP_REQUEST, 32'h0A00_0009, 48'h1, 32'hC0A8_0001), 1'b1,
                              rsp_type'{ACT_DROP, 48'h0, 32'h0}});
      directed_rows.push_back(stim_row_type'{pkt(KIND_PACKET, 16'd60, HW_ETHERNET, 16'hFFFF,
                              OP_REQUEST, 32'h0A00_0009, 48'h1, 32'hC0A8_0001), 1'b1,
                              rsp_type'{ACT_DROP, 48'h0, 32'h0}});
      directed_rows.push_back(stim_row_type'{pkt(KIND_PACKET, 16'd28, HW_ETHERNET, PROTO_IPV4,
                              OP_REPLY, 32'h0A00_0001, 48'h0011_2233_4455, 32'h0A00_0002),
                              1'b1, rsp_type'{ACT_LEARN, 48'h0, 32'h0}});
      directed_rows.push_back(stim_row_type'{pkt(KIND_RESOLVE, 0, 0, 0, 0, 0, 0, 32'h0A00_0001),
                              1'b0, none});
      // known sender, request for us: overwrite and reply
      directed_rows.push_back(stim_row_type'{pkt(KIND_PACKET, 16'hFFFF, HW_ETHERNET, PROTO_IPV4,
                              OP_REQUEST, 32'h0A00_0001, 48'hAABB_CCDD_EEFF, 32'hC0A8_0001),
                              1'b0, none});
      directed_rows.push_back(stim_row_type'{pkt(KIND_RESOLVE, 0, 0, 0, 0, 0, 0, 32'h0A00_0001),
                              1'b0, none});
      directed_rows.push_back(stim_row_type'{pkt(KIND_PACKET, 16'd28, HW_ETHERNET, PROTO_IPV4,
                              16'd0, 32'h0, 48'h0, 32'hC0A8_0001), 1'b0, none});
      directed_rows.push_back(stim_row_type'{pkt(KIND_PACKET, 16'd28, HW_ETHERNET, PROTO_IPV4,
                              16'hFFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hC0A8_0001),
                              1'b0, none});
      directed_rows.push_back(stim_row_type'{pkt(KIND_PACKET, 16'd42, HW_ETHERNET, PROTO_IPV4,
                              OP_REQUEST, 32'h0A00_0003, 48'h0200_0000_0003, 32'hC0A8_0002),
                              1'b0, none});
      directed_rows.push_back(stim_row_type'{pkt(KIND_PACKET, 16'd42, HW_ETHERNET, PROTO_IPV4,
                              OP_REPLY, 32'h0A00_0004, 48'h0200_0000_0004, 32'hC0A8_0001),
                              1'b0, none});
      // resolve ignores the packet fields
      directed_rows.push_back(stim_row_type'{pkt(KIND_RESOLVE, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              16'hFFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h0), 1'b0, none});
      directed_rows.push_back(stim_row_type'{pkt(KIND_RESOLVE, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF),
                              1'b0, none});
      directed_rows.push_back(stim_row_type'{pkt(KIND_PACKET, 16'd28, HW_ETHERNET, PROTO_IPV4,
                              OP_REQUEST, 32'hFFFF_FFFF, 48'h0000_0000_0001, 32'hC0A8_0001),
                              1'b0, none});

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      csr_write(CSR_OWN_IP, 64'hC0A8_0001);
      csr_write(CSR_OWN_MAC, 64'h0200_0000_0001);
      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want,
                   draw_gap());
      wait_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         csr_write(CSR_OWN_IP, 64'(own_ip_set[p]));
         csr_write(CSR_OWN_MAC, 64'(own_mac_set[p]));
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_item(random_item(), 1'b0, none, draw_gap());
            if ($urandom_range(0, 63) == 0) wait_drained();
         end
         wait_drained();
      end

      repeat (30) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
